// ===== rtl/gdd_pkg.sv =====
// Shared types, constants and calendar functions for the date decrement core.
`timescale 1ns / 1ps
package gdd_pkg;

  // span unit codes
  typedef enum logic [2:0] {
    REQ_DAY     = 3'd0,
    REQ_WEEK    = 3'd1,
    REQ_MONTH   = 3'd2,
    REQ_YEAR    = 3'd3,
    REQ_DECADE  = 3'd4,
    REQ_CENTURY = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic load;     // capture and normalize the input beat
    logic step;     // one iteration of the day or month walk
    logic publish;  // move the finished date into the output register
  } gdd_cmd_t;

  typedef struct packed {
    logic done;     // nothing left to subtract
  } gdd_sts_t;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 16;
  localparam int CountW = 15;
  localparam int RemW   = 18;  // holds 7 * max count

  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
  localparam logic [DayW-1:0]   DAY_LAST_DEC = 5'd31;
  localparam logic [DayW-1:0]   FEB_LEAP = 5'd29;
  localparam logic [DayW-1:0]   FEB_PLAIN = 5'd28;

  localparam logic [DayW-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Divisibility by 25 through the modular inverse: the year is biased by a
  // multiple of 25 to make it non-negative, then x*inv mod 2^17 <= (2^17-1)/25
  // exactly when x is a multiple of 25.
  localparam logic [16:0] DIV25_BIAS  = 17'd32775;
  localparam logic [16:0] DIV25_INV   = 17'd89129;
  localparam logic [16:0] DIV25_LIMIT = 17'd5242;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [16:0] u;
    logic [16:0] q;
    logic        div25;
    u     = {y[YearW-1], y} + DIV25_BIAS;
    q     = u * DIV25_INV;
    div25 = (q <= DIV25_LIMIT);
    // by 4 and not by 100, or by 400 (by 4 settled, 100 -> 25, 400 -> 16 and 25)
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m,
                                              input logic [YearW-1:0] y);
    logic [MonthW-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == MONTH_FEB) begin
      return is_leap(y) ? FEB_LEAP : FEB_PLAIN;
    end
    return MONTH_LEN[idx];
  endfunction

endpackage

// ===== rtl/gdd_ctrl.sv =====
// Sequencer for the date decrement core: load, iterate, publish.
`timescale 1ns / 1ps
module gdd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gdd_pkg::gdd_sts_t sts,
  output gdd_pkg::gdd_cmd_t cmd
);
  import gdd_pkg::*;

  state_t st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.publish = 1'b1;
          st_nxt      = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st_r == ST_IDLE) else $error("load outside idle");
  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.done && st_r == ST_RUN) else $error("step after done");
  a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> sts.done && out_free) else $error("publish over pending beat");
  a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r && st_r == ST_IDLE) else $error("publish lost");

endmodule

// ===== rtl/gdd_datapath.sv =====
// Date registers, remaining count and step logic of the date decrement core.
`timescale 1ns / 1ps
module gdd_datapath (
  input  logic                           clk,
  input  gdd_pkg::gdd_cmd_t              cmd,
  output gdd_pkg::gdd_sts_t              sts,
  input  logic [2:0]                     in_req_type,
  input  logic [gdd_pkg::CountW-1:0]     in_span_count,
  input  logic [gdd_pkg::DayW-1:0]       in_start_day,
  input  logic [gdd_pkg::MonthW-1:0]     in_start_month,
  input  logic signed [gdd_pkg::YearW-1:0] in_start_year,
  output logic [gdd_pkg::DayW-1:0]       out_result_day,
  output logic [gdd_pkg::MonthW-1:0]     out_result_month,
  output logic signed [gdd_pkg::YearW-1:0] out_result_year
);
  import gdd_pkg::*;

  logic [DayW-1:0]   d_r, d_nxt;
  logic [MonthW-1:0] m_r, m_nxt;
  logic [YearW-1:0]  y_r, y_nxt;
  logic [RemW-1:0]   rem_r, rem_nxt;
  logic              month_mode_r, month_mode_nxt;
  logic [DayW-1:0]   od_r;
  logic [MonthW-1:0] om_r;
  logic [YearW-1:0]  oy_r;

  logic [DayW-1:0]   d_in, dm1, prev_len;
  logic [MonthW-1:0] m_in, m_prev;
  logic [YearW-1:0]  y_in, y_prev;
  logic [RemW-1:0]   cnt_x7;
  logic [YearW-1:0]  cnt_x10;
  logic [YearW-1:0]  cnt_x100;

  assign d_in = (in_start_day == '0) ? 5'd1 : in_start_day;
  assign m_in = (in_start_month == '0) ? MONTH_JAN :
                (in_start_month > MONTH_DEC) ? MONTH_DEC : in_start_month;
  assign y_in = in_start_year;

  assign cnt_x7   = RemW'(in_span_count) * 18'd7;
  // only the low year bits matter, the year wraps anyway
  assign cnt_x10  = YearW'(in_span_count) * 16'd10;
  assign cnt_x100 = YearW'(in_span_count) * 16'd100;

  // month before the current one, with its year and length
  assign m_prev   = (m_r == MONTH_JAN) ? MONTH_DEC : m_r - 4'd1;
  assign y_prev   = (m_r == MONTH_JAN) ? y_r - 16'd1 : y_r;
  assign prev_len = days_in(m_prev, y_prev);
  assign dm1      = d_r - 5'd1;

  assign sts.done = (rem_r == '0);

  always_comb begin
    d_nxt          = d_r;
    m_nxt          = m_r;
    y_nxt          = y_r;
    rem_nxt        = rem_r;
    month_mode_nxt = month_mode_r;
    if (cmd.load) begin
      d_nxt          = d_in;
      m_nxt          = m_in;
      y_nxt          = y_in;
      rem_nxt        = '0;
      month_mode_nxt = 1'b0;
      unique case (in_req_type)
        REQ_DAY:     rem_nxt = RemW'(in_span_count);
        REQ_WEEK:    rem_nxt = cnt_x7;
        REQ_MONTH: begin
          rem_nxt        = RemW'(in_span_count);
          month_mode_nxt = 1'b1;
        end
        REQ_YEAR:    y_nxt = y_in - YearW'(in_span_count);
        REQ_DECADE:  y_nxt = y_in - cnt_x10;
        REQ_CENTURY: y_nxt = y_in - cnt_x100;
        default:     ;
      endcase
    end else if (cmd.step) begin
      if (month_mode_r) begin
        m_nxt   = m_prev;
        y_nxt   = y_prev;
        d_nxt   = (d_r > prev_len) ? prev_len : d_r;
        rem_nxt = rem_r - 18'd1;
      end else if (d_r > 5'd1) begin
        // slide down within the month in one go
        if (rem_r < RemW'(dm1)) begin
          d_nxt   = d_r - rem_r[DayW-1:0];
          rem_nxt = '0;
        end else begin
          d_nxt   = 5'd1;
          rem_nxt = rem_r - RemW'(dm1);
        end
      end else begin
        m_nxt   = m_prev;
        y_nxt   = y_prev;
        d_nxt   = prev_len;
        rem_nxt = rem_r - 18'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r          <= d_nxt;
    m_r          <= m_nxt;
    y_r          <= y_nxt;
    rem_r        <= rem_nxt;
    month_mode_r <= month_mode_nxt;
    if (cmd.publish) begin
      od_r <= d_r;
      om_r <= m_r;
      oy_r <= y_r;
    end
  end

  assign out_result_day   = od_r;
  assign out_result_month = om_r;
  assign out_result_year  = $signed(oy_r);

endmodule

// ===== rtl/gregorian_date_decrement_core.sv =====
// Sequence: load, the walk, publish once the output register is free. Year,
// decade and century spans skip the walk; a day or week span takes about two
// steps per month it crosses (slide to day 1, then roll back), a month span one.
// One beat in flight at a time; the next beat is taken as soon as the result
// sits in the output register, even while that result is stalled.
// rst_n (synchronous, active low) clears the sequencer and the output valid.
`timescale 1ns / 1ps
module gregorian_date_decrement_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_req_type,
  input  logic [gdd_pkg::CountW-1:0]       in_span_count,
  input  logic [gdd_pkg::DayW-1:0]         in_start_day,
  input  logic [gdd_pkg::MonthW-1:0]       in_start_month,
  input  logic signed [gdd_pkg::YearW-1:0] in_start_year,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gdd_pkg::DayW-1:0]         out_result_day,
  output logic [gdd_pkg::MonthW-1:0]       out_result_month,
  output logic signed [gdd_pkg::YearW-1:0] out_result_year
);
  import gdd_pkg::*;

  gdd_cmd_t cmd;
  gdd_sts_t sts;

  gdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdd_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_span_count    (in_span_count),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year)
  );

endmodule
